[sv/hcm_pkg.sv]
// ----------------------------------------------------------------------------
// HSV color mask package
// Register indexes, reset values, field widths and shared register types.
// ----------------------------------------------------------------------------
package hcm_pkg;

    localparam int MAX_COLORS = 5;
    localparam int HUE_W      = 10;
    localparam int SAT_W      = 8;
    localparam int VAL_W      = 8;
    localparam int WIN_W      = 28;
    localparam int LINE_W_W   = 11;
    localparam int FRAME_H_W  = 13;
    localparam int ROWCNT_W   = 14;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_WIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_WIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PINK_WIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_WIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW_WIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BG_WIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H    = 3'd7;

    // Item kinds on the input channel.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Color window register: saturation minimum, hue high, hue low.
    typedef struct packed {
        logic [SAT_W-1:0] sat_min;
        logic [HUE_W-1:0] hue_hi;
        logic [HUE_W-1:0] hue_lo;
    } color_win_t;

    // Background register: saturation minimum, value minimum.
    typedef struct packed {
        logic [SAT_W-1:0] sat_min;
        logic [VAL_W-1:0] val_min;
    } bg_win_t;

    localparam logic [WIN_W-1:0] RST_BLUE_WIN   = 28'd147555901;
    localparam logic [WIN_W-1:0] RST_GREEN_WIN  = 28'd81244447;
    localparam logic [WIN_W-1:0] RST_PINK_WIN   = 28'd107941683;
    localparam logic [WIN_W-1:0] RST_RED_WIN    = 28'd174106583;
    localparam logic [WIN_W-1:0] RST_YELLOW_WIN = 28'd174283899;
    localparam logic [15:0]          RST_BG_WIN     = 16'd7962;
    localparam logic [LINE_W_W-1:0]  RST_LINE_WIDTH = 11'd640;
    localparam logic [FRAME_H_W-1:0] RST_FRAME_H    = 13'd480;

endpackage

[sv/hsv_color_mask_median.sv]
// ----------------------------------------------------------------------------
// HSV color mask with square binary median
// Thresholds raster HSV pixels into per-color masks and median-filters them.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while s_tready is high
// and hands out at most one result per transaction; a result passes the
// stage 1, stage 2, stage 3 and output registers. While a result waits,
// input is taken until the three stages behind the output register are full.
// Filtered pixels lag the input by WINDOW/2 rows plus WINDOW/2 pixels, so the
// end of each frame is pushed out with flush transactions (or pixels, which
// are dropped while a frame drains); a flush during frame input is ignored.
// The raw masks of the last WINDOW-1 rows live in WINDOW-1 line buffers, each
// read once per cycle at the current column, and the window itself is a chain
// of WINDOW cells holding per-color column counts. Borders are replicated.
// Writing line_width or frame_height abandons the frame in progress. There is
// no clearing pass: the line buffers are never read before they are written.
module hsv_color_mask_median #(
    parameter int MAX_WIDTH  = 1024,
    parameter int NUM_COLORS = 5,
    parameter int WINDOW     = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel. s_tdata: hue[9:0], sat[17:10], val[25:18], zero pad.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,    // opcode: pixel or flush
    // Result channel. m_tdata: color_masks[4:0], zero pad.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tuser,    // line_end
    output logic        m_tlast,    // frame_end
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [hcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hcm_pkg::WIN_W-1:0]       cfg_wdata
);

    localparam int HALF  = WINDOW / 2;
    localparam int SPAN  = 2 * HALF + 1;
    localparam int RING  = 2 * HALF;
    localparam int CELLS = SPAN * SPAN;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int SL    = (RING > 1) ? $clog2(RING) : 1;
    localparam int IW    = $clog2(SPAN);
    localparam int CW    = $clog2(SPAN + 1);
    localparam int SUMW  = $clog2(CELLS + 1);
    localparam int PW    = $clog2(HALF + 1);
    localparam int TW    = $clog2(3 * RING);
    localparam int HW    = hcm_pkg::FRAME_H_W;
    localparam int RW    = hcm_pkg::ROWCNT_W;
    localparam int CMPW  = RW + 1;

    // Configuration registers.
    hcm_pkg::color_win_t [hcm_pkg::MAX_COLORS-1:0] color_win_reg;
    hcm_pkg::bg_win_t                  bg_win_reg;
    logic [hcm_pkg::LINE_W_W-1:0]      line_width_reg;
    logic [HW-1:0]                     frame_h_reg;

    // Stream position counters.
    logic [AW-1:0] in_col_reg;
    logic [HW-1:0] in_row_reg;
    logic [SL-1:0] in_slot_reg;
    logic [AW-1:0] x_reg;
    logic [RW-1:0] r_reg;
    logic [SL-1:0] rslot_reg;
    logic [PW-1:0] prime_reg;
    logic [AW-1:0] out_col_reg;
    logic [HW-1:0] out_row_reg;

    logic [WW-1:0] w_eff, w_last, dist_r;
    logic [HW-1:0] h_eff, h_last;
    logic          acc, drain, pix, evt, emit, le, fe, x_last, col_last, restart;
    logic          r1, r2, r3, r4;
    logic [NUM_COLORS-1:0] pix_mask;

    logic [SPAN-1:0][SL-1:0] slot_sel;
    logic [SPAN-1:0][IW-1:0] b_sel;
    logic [TW-1:0]           fold;

    // Stage 1: line buffer read out.
    logic                          v1_reg, zero1_reg, cur1_reg, emit1_reg, le1_reg, fe1_reg;
    logic [SPAN-1:0][SL-1:0]       slot1_reg;
    logic [SPAN-1:0][IW-1:0]       b1_reg;
    logic [NUM_COLORS-1:0]         mask1_reg;
    logic [RING-1:0][NUM_COLORS-1:0] lb_rd;

    // Stage 2: column entered the window chain.
    logic                          v2_reg, emit2_reg, le2_reg, fe2_reg;
    logic [SPAN-1:0][IW-1:0]       b2_reg;
    logic [SPAN-1:0][NUM_COLORS-1:0]          col;
    logic [NUM_COLORS-1:0][CW-1:0]            col_cnt;
    logic [SPAN-1:0][NUM_COLORS-1:0][CW-1:0]  cell_cnt;

    // Stage 3: border-resolved column counts.
    logic                          v3_reg, le3_reg, fe3_reg;
    logic [SPAN-1:0][NUM_COLORS-1:0][CW-1:0]  sel3_reg;
    logic [NUM_COLORS-1:0][SUMW-1:0]          sum;
    logic [7:0]                               median_bits;

    // Output register.
    logic       m_tvalid_reg, m_tuser_reg, m_tlast_reg;
    logic [7:0] m_tdata_reg;

    // ---------------------------------------------------------------------
    // Effective sizes.
    // ---------------------------------------------------------------------
    always_comb begin
        if (line_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(line_width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(line_width_reg);
        end
        h_eff  = (frame_h_reg == '0) ? HW'(1) : frame_h_reg;
        w_last = w_eff - WW'(1);
        h_last = h_eff - HW'(1);
    end

    // ---------------------------------------------------------------------
    // Handshake. Each stage may load when it is empty or its content moves.
    // ---------------------------------------------------------------------
    assign r4       = !m_tvalid_reg || m_tready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign s_tready = r1;
    assign acc      = s_tvalid && r1;

    hcm_classify #(.NUM_COLORS(NUM_COLORS)) u_classify (
        .hue       (s_tdata[9:0]),
        .sat       (s_tdata[17:10]),
        .val       (s_tdata[25:18]),
        .color_win (color_win_reg),
        .bg_win    (bg_win_reg),
        .mask      (pix_mask)
    );

    // ---------------------------------------------------------------------
    // Transaction decode. A column event shifts one column into the window;
    // it comes from a pixel once HALF rows are buffered, or from any
    // transaction while the frame drains.
    // ---------------------------------------------------------------------
    always_comb begin
        drain    = in_row_reg >= h_eff;
        pix      = !drain && (s_tuser == hcm_pkg::OP_PIXEL);
        evt      = drain || (pix && (in_row_reg >= HW'(HALF)));
        emit     = evt && (prime_reg == PW'(HALF));
        le       = WW'(out_col_reg) == w_last;
        fe       = le && (out_row_reg == h_last);
        x_last   = WW'(x_reg) == w_last;
        col_last = WW'(in_col_reg) == w_last;
        restart  = acc && emit && fe;
        dist_r   = w_last - WW'(out_col_reg);
    end

    // Line buffer slot feeding each window row, with top and bottom clamping.
    always_comb begin
        fold = '0;
        for (int i = 0; i < SPAN; i++) begin
            fold = TW'(rslot_reg) + TW'(RING + i - HALF);
            if (fold >= TW'(2 * RING)) begin
                fold = fold - TW'(2 * RING);
            end else if (fold >= TW'(RING)) begin
                fold = fold - TW'(RING);
            end
            if ((CMPW'(r_reg) + CMPW'(i)) < CMPW'(HALF)) begin
                slot_sel[i] = '0;
            end else if ((CMPW'(r_reg) + CMPW'(i)) >
                         (CMPW'(h_eff) + CMPW'(HALF) - CMPW'(1))) begin
                // Bottom border: the last row of the frame, one slot behind.
                slot_sel[i] = (in_slot_reg == '0) ? SL'(RING - 1) : in_slot_reg - SL'(1);
            end else begin
                slot_sel[i] = SL'(fold);
            end
        end
    end

    // Window column used for each horizontal tap, with left and right clamping.
    always_comb begin
        for (int d = 0; d < SPAN; d++) begin
            if ((d < HALF) && (WW'(out_col_reg) < WW'(HALF - d))) begin
                b_sel[d] = IW'(out_col_reg) + IW'(HALF);
            end else if ((d > HALF) && (dist_r < WW'(d - HALF))) begin
                b_sel[d] = IW'(HALF) - IW'(dist_r);
            end else begin
                b_sel[d] = IW'(2 * HALF - d);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Configuration and counters.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_win_reg[0] <= hcm_pkg::RST_BLUE_WIN;
            color_win_reg[1] <= hcm_pkg::RST_GREEN_WIN;
            color_win_reg[2] <= hcm_pkg::RST_PINK_WIN;
            color_win_reg[3] <= hcm_pkg::RST_RED_WIN;
            color_win_reg[4] <= hcm_pkg::RST_YELLOW_WIN;
            bg_win_reg       <= hcm_pkg::RST_BG_WIN;
            line_width_reg   <= hcm_pkg::RST_LINE_WIDTH;
            frame_h_reg      <= hcm_pkg::RST_FRAME_H;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_slot_reg <= '0;
            x_reg       <= '0;
            r_reg       <= '0;
            rslot_reg   <= '0;
            prime_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hcm_pkg::REG_BLUE_WIN:   color_win_reg[0] <= cfg_wdata;
                hcm_pkg::REG_GREEN_WIN:  color_win_reg[1] <= cfg_wdata;
                hcm_pkg::REG_PINK_WIN:   color_win_reg[2] <= cfg_wdata;
                hcm_pkg::REG_RED_WIN:    color_win_reg[3] <= cfg_wdata;
                hcm_pkg::REG_YELLOW_WIN: color_win_reg[4] <= cfg_wdata;
                hcm_pkg::REG_BG_WIN:     bg_win_reg <= cfg_wdata[15:0];
                hcm_pkg::REG_LINE_WIDTH,
                hcm_pkg::REG_FRAME_H: begin
                    if (cfg_index == hcm_pkg::REG_LINE_WIDTH) begin
                        line_width_reg <= cfg_wdata[hcm_pkg::LINE_W_W-1:0];
                    end else begin
                        frame_h_reg <= cfg_wdata[HW-1:0];
                    end
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    in_slot_reg <= '0;
                    x_reg       <= '0;
                    r_reg       <= '0;
                    rslot_reg   <= '0;
                    prime_reg   <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                default: ;
            endcase
        end else if (restart) begin
            // Frame finished: everything returns to the start of a new frame.
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_slot_reg <= '0;
            x_reg       <= '0;
            r_reg       <= '0;
            rslot_reg   <= '0;
            prime_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (acc) begin
            if (pix) begin
                if (col_last) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + HW'(1);
                    in_slot_reg <= (in_slot_reg == SL'(RING - 1)) ? '0 : in_slot_reg + SL'(1);
                end else begin
                    in_col_reg <= in_col_reg + AW'(1);
                end
            end
            if (evt) begin
                if (x_last) begin
                    x_reg     <= '0;
                    r_reg     <= r_reg + RW'(1);
                    rslot_reg <= (rslot_reg == SL'(RING - 1)) ? '0 : rslot_reg + SL'(1);
                end else begin
                    x_reg <= x_reg + AW'(1);
                end
                if (prime_reg != PW'(HALF)) begin
                    prime_reg <= prime_reg + PW'(1);
                end
            end
            if (emit) begin
                if (le) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + HW'(1);
                end else begin
                    out_col_reg <= out_col_reg + AW'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Line buffers: one slot per buffered row.
    // ---------------------------------------------------------------------
    for (genvar s = 0; s < RING; s++) begin : g_lb
        hcm_line_buf #(.DEPTH(MAX_WIDTH), .DW(NUM_COLORS)) u_lb (
            .aclk    (aclk),
            .wr_en   (acc && pix && (in_slot_reg == SL'(s))),
            .wr_addr (in_col_reg),
            .wr_data (pix_mask),
            .rd_en   (acc && evt),
            .rd_addr (x_reg),
            .rd_data (lb_rd[s])
        );
    end

    // ---------------------------------------------------------------------
    // Pipeline stages.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= acc && evt;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg && emit2_reg;
            end
            if (r4) begin
                m_tvalid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && evt) begin
            slot1_reg <= slot_sel;
            b1_reg    <= b_sel;
            zero1_reg <= CMPW'(r_reg) >= CMPW'(h_eff);
            cur1_reg  <= !drain;
            mask1_reg <= pix_mask;
            emit1_reg <= emit;
            le1_reg   <= le;
            fe1_reg   <= fe;
        end
        if (r2 && v1_reg) begin
            b2_reg    <= b1_reg;
            emit2_reg <= emit1_reg;
            le2_reg   <= le1_reg;
            fe2_reg   <= fe1_reg;
        end
        if (r3 && v2_reg && emit2_reg) begin
            for (int d = 0; d < SPAN; d++) begin
                sel3_reg[d] <= cell_cnt[b2_reg[d]];
            end
            le3_reg <= le2_reg;
            fe3_reg <= fe2_reg;
        end
        if (r4 && v3_reg) begin
            m_tdata_reg <= median_bits;
            m_tuser_reg <= le3_reg;
            m_tlast_reg <= fe3_reg;
        end
    end

    // New column: rows from the line buffers, the current row from the pixel.
    always_comb begin
        for (int i = 0; i < SPAN; i++) begin
            if (zero1_reg) begin
                col[i] = '0;
            end else if (cur1_reg && (i == SPAN - 1)) begin
                col[i] = mask1_reg;
            end else begin
                col[i] = lb_rd[slot1_reg[i]];
            end
        end
        for (int k = 0; k < NUM_COLORS; k++) begin
            col_cnt[k] = '0;
            for (int i = 0; i < SPAN; i++) begin
                col_cnt[k] = col_cnt[k] + CW'(col[i][k]);
            end
        end
    end

    // Window chain: cell 0 holds the newest column.
    for (genvar j = 0; j < SPAN; j++) begin : g_cell
        hcm_win_cell #(.NUM_COLORS(NUM_COLORS), .CW(CW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (r2 && v1_reg),
            .cnt_in   ((j == 0) ? col_cnt : cell_cnt[(j == 0) ? 0 : j - 1]),
            .cnt_out  (cell_cnt[j])
        );
    end

    // A color is on when more than half of the window cells are set.
    always_comb begin
        median_bits = '0;
        for (int k = 0; k < NUM_COLORS; k++) begin
            sum[k] = '0;
            for (int d = 0; d < SPAN; d++) begin
                sum[k] = sum[k] + SUMW'(sel3_reg[d][k]);
            end
            median_bits[k] = sum[k] > SUMW'(CELLS / 2);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_frame_end_on_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tlast_reg |-> m_tuser_reg)
        else $error("frame end without line end");

    a_event_column_tracks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_row_reg >= HW'(HALF)) && (in_row_reg < h_eff) |-> x_reg == in_col_reg)
        else $error("window column out of step with input column");

    a_out_column_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(out_col_reg) <= w_last)
        else $error("output column beyond line width");

    a_unused_colors_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg >> NUM_COLORS) == 8'd0)
        else $error("mask bit set for a color that does not exist");

endmodule

[sv/hcm_classify.sv]
// ----------------------------------------------------------------------------
// HSV color classifier
// Builds the raw per-color mask of one pixel from the threshold registers.
// ----------------------------------------------------------------------------
module hcm_classify #(
    parameter int NUM_COLORS = 5
) (
    input  logic [hcm_pkg::HUE_W-1:0]  hue,
    input  logic [hcm_pkg::SAT_W-1:0]  sat,
    input  logic [hcm_pkg::VAL_W-1:0]  val,
    input  hcm_pkg::color_win_t [hcm_pkg::MAX_COLORS-1:0] color_win,
    input  hcm_pkg::bg_win_t           bg_win,
    output logic [NUM_COLORS-1:0]      mask
);

    logic fg;
    logic [NUM_COLORS-1:0] in_hue;

    assign fg = (val > bg_win.val_min) && (sat > bg_win.sat_min);

    always_comb begin
        for (int k = 0; k < NUM_COLORS; k++) begin
            // A window whose low bound lies above its high bound wraps through zero.
            if (color_win[k].hue_lo <= color_win[k].hue_hi) begin
                in_hue[k] = (hue > color_win[k].hue_lo) && (hue < color_win[k].hue_hi);
            end else begin
                in_hue[k] = (hue > color_win[k].hue_lo) || (hue < color_win[k].hue_hi);
            end
            mask[k] = fg && in_hue[k] && (sat > color_win[k].sat_min);
        end
    end

endmodule

[sv/hcm_line_buf.sv]
// ----------------------------------------------------------------------------
// Mask line buffer
// One image row of raw masks, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hcm_line_buf #(
    parameter int DEPTH = 1024,
    parameter int DW    = 5
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data
);

    logic [DW-1:0] mem [DEPTH];

    // A read in the same cycle as a write to that address returns the old entry.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/hcm_win_cell.sv]
// ----------------------------------------------------------------------------
// Median window cell
// Holds the per-color set count of one window column and passes it on.
// ----------------------------------------------------------------------------
module hcm_win_cell #(
    parameter int NUM_COLORS = 5,
    parameter int CW         = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              shift_en,
    input  logic [NUM_COLORS-1:0][CW-1:0]     cnt_in,
    output logic [NUM_COLORS-1:0][CW-1:0]     cnt_out
);

    logic [NUM_COLORS-1:0][CW-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (shift_en) begin
            cnt_reg <= cnt_in;
        end
    end

    assign cnt_out = cnt_reg;

endmodule
